### sv/mexp_pkg.sv
// Shared types and constants for the modular exponentiation unit.
`timescale 1ns / 1ps
`default_nettype none

package mexp_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned PROD_W = 2 * DATA_W;

  localparam logic [DATA_W-1:0] MODULUS_RESET = 32'd1000000007;

  // Operation codes on the cmd field
  localparam logic CMD_POWER   = 1'b0;
  localparam logic CMD_INVERSE = 1'b1;

  // Request to the shared multiply-reduce unit
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } mexp_req_t;

  // Response from the shared multiply-reduce unit
  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] res;
  } mexp_rsp_t;

  // Sequencer states
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_BRED = 6'b000010,
    ST_STEP = 6'b000100,
    ST_MUL  = 6'b001000,
    ST_SQR  = 6'b010000,
    ST_FIN  = 6'b100000
  } mexp_state_t;

endpackage

`default_nettype wire

### sv/mexp_if.sv
// Valid/ready channel interfaces for request, result and configuration.
`timescale 1ns / 1ps
`default_nettype none

interface mexp_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] base;
  logic [31:0] exponent;

  modport source (output valid, output cmd, output base, output exponent, input ready);
  modport sink   (input valid, input cmd, input base, input exponent, output ready);
endinterface

interface mexp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface mexp_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### sv/mexp_mulmod.sv
// Shared multiply-reduce unit: (a * b) mod m, two remainder bits per cycle.
`timescale 1ns / 1ps
`default_nettype none

module mexp_mulmod (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [mexp_pkg::DATA_W-1:0] m,
  input  wire mexp_pkg::mexp_req_t        req,
  output mexp_pkg::mexp_rsp_t             rsp
);
  import mexp_pkg::*;

  localparam int unsigned STEPS = PROD_W / 2;
  localparam int unsigned CNT_W = $clog2(STEPS);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;

  logic [DATA_W:0] m_ext;
  logic [DATA_W:0] t1, r1, t2, r2;

  // Two restoring remainder steps on the top product bits
  always_comb begin
    m_ext = {1'b0, m};
    t1    = {rem_r, prod_r[PROD_W-1]};
    r1    = (t1 >= m_ext) ? (t1 - m_ext) : t1;
    t2    = {r1[DATA_W-1:0], prod_r[PROD_W-2]};
    r2    = (t2 >= m_ext) ? (t2 - m_ext) : t2;
  end

  // Load on start, then shift the product through the remainder
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    prod_nxt = prod_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      prod_nxt = PROD_W'(req.a) * PROD_W'(req.b);
      rem_nxt  = '0;
    end else if (busy_r) begin
      prod_nxt = {prod_r[PROD_W-3:0], 2'b00};
      rem_nxt  = r2[DATA_W-1:0];
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.res  = rem_r;

endmodule

`default_nettype wire

### sv/modular_exponentiation_unit.sv
// Top level: modular exponentiation by right-to-left square-and-multiply.
// A zero modulus or zero effective exponent goes straight to the result; otherwise
//   the base is reduced first, then each set exponent bit takes a multiply and each
//   bit below the top one a square, all in the shared multiply-reduce unit.
// Throughput: one request at a time; the next is taken once the result is latched.
// Reset (rst_n low, synchronous): sequencer idle, no result pending, modulus 1000000007.
`timescale 1ns / 1ps
`default_nettype none

module modular_exponentiation_unit #(
  parameter int unsigned EXP_BITS = 32
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  mexp_in_if.sink        in_ch,
  mexp_out_if.source     out_ch,
  mexp_cfg_if.sink       cfg_ch
);
  import mexp_pkg::*;

  localparam int unsigned EW = (EXP_BITS < DATA_W) ? EXP_BITS : DATA_W;

  mexp_state_t       state_r, state_nxt;
  logic [DATA_W-1:0] modulus_r;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic [DATA_W-1:0] x_r, x_nxt;
  logic [EW-1:0]     e_r, e_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] value_r, value_nxt;

  mexp_req_t         req;
  mexp_rsp_t         rsp;
  logic              in_fire;
  logic [DATA_W-1:0] e_full;
  logic [EW-1:0]     e_eff;

  // Shared multiply-reduce unit
  mexp_mulmod u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .m     (modulus_r),
    .req   (req),
    .rsp   (rsp)
  );

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;

  // Effective exponent: given one, or modulus - 2 (zero if modulus < 2) for the inverse; cut to EW bits
  always_comb begin
    if (in_ch.cmd == CMD_INVERSE) begin
      e_full = (modulus_r < DATA_W'(2)) ? '0 : (modulus_r - DATA_W'(2));
    end else begin
      e_full = in_ch.exponent;
    end
    e_eff = e_full[EW-1:0];
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    x_nxt         = x_r;
    e_nxt         = e_r;
    out_valid_nxt = out_valid_r;
    value_nxt     = value_r;
    req.start     = 1'b0;
    req.a         = x_r;
    req.b         = x_r;

    if (out_ch.valid && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          e_nxt = e_eff;
          if (modulus_r == '0) begin
            acc_nxt   = '0;
            state_nxt = ST_FIN;
          end else if (e_eff == '0) begin
            acc_nxt   = DATA_W'(1);
            state_nxt = ST_FIN;
          end else begin
            // reduce the base first: base * 1 mod m
            acc_nxt   = DATA_W'(1);
            req.start = 1'b1;
            req.a     = in_ch.base;
            req.b     = DATA_W'(1);
            state_nxt = ST_BRED;
          end
        end
      end
      ST_BRED: begin
        if (rsp.done) begin
          x_nxt     = rsp.res;
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        req.start = 1'b1;
        if (e_r[0]) begin
          req.a     = acc_r;
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_SQR;
        end
      end
      ST_MUL: begin
        if (rsp.done) begin
          acc_nxt = rsp.res;
          if ((e_r >> 1) == '0) begin
            // last set bit: the final square is not needed
            state_nxt = ST_FIN;
          end else begin
            req.start = 1'b1;
            state_nxt = ST_SQR;
          end
        end
      end
      ST_SQR: begin
        if (rsp.done) begin
          x_nxt     = rsp.res;
          e_nxt     = e_r >> 1;
          state_nxt = ST_STEP;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          value_nxt     = acc_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      modulus_r   <= MODULUS_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        modulus_r <= cfg_ch.data;
      end
    end
    acc_r   <= acc_nxt;
    x_r     <= x_nxt;
    e_r     <= e_nxt;
    value_r <= value_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.value = value_r;

endmodule

`default_nettype wire
